/* rtl/core/srt_pkg.sv */
package srt_pkg;

  localparam int unsigned MAX_RECORDS_DEFAULT = 16;
  localparam int unsigned RESULT_LIMIT        = 16;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LIST   = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_FIND   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_NO_MATCH  = 3'd4;

  // Reciprocal multipliers for exact division by 100 of the birth date
  // and of its quotient.
  localparam logic [33:0] DIV100_MUL_WIDE   = 34'd10995116278;
  localparam logic [25:0] DIV100_MUL_NARROW = 26'd42949673;
  localparam logic [20:0] MONTH_BASE        = 21'd100;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] name_high;
    logic [63:0] name_mid;
    logic [31:0] name_low;
    logic [63:0] phone_high;
    logic [55:0] phone_low;
    logic [26:0] birth_date;
    logic [6:0]  search_month;
  } req_t;

  typedef struct packed {
    logic [63:0] out_name_high;
    logic [63:0] out_name_mid;
    logic [31:0] out_name_low;
    logic [63:0] out_phone_high;
    logic [55:0] out_phone_low;
    logic [26:0] out_birth_date;
    logic [4:0]  record_count;
    logic [2:0]  status;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [63:0] name_high;
    logic [63:0] name_mid;
    logic [31:0] name_low;
    logic [63:0] phone_high;
    logic [55:0] phone_low;
    logic [26:0] birth_date;
  } rec_t;

  typedef struct packed {
    rec_t       rec;
    logic [6:0] month;
  } entry_t;

  typedef enum logic [2:0] {
    PTR_HOLD, PTR_LOAD, PTR_CLEAR, PTR_INC, PTR_DEC
  } ptr_op_e;

  typedef enum logic [1:0] {
    RD_SAME, RD_MINUS, RD_PLUS
  } rd_off_e;

  typedef enum logic [1:0] {
    WR_NONE, WR_KEY, WR_RDATA
  } wr_e;

  typedef enum logic [1:0] {
    CNT_HOLD, CNT_INC, CNT_DEC
  } cnt_e;

  typedef enum logic [1:0] {
    EMIT_NONE, EMIT_ZERO, EMIT_KEY, EMIT_HOLD
  } emit_e;

  typedef struct packed {
    logic       key_ld;
    ptr_op_e    ptr_op;
    rd_off_e    rd_off;
    wr_e        wr;
    cnt_e       cnt;
    logic       hold_ld;
    logic       hold_clr;
    logic       match_inc;
    logic       match_clr;
    emit_e      emit;
    logic [2:0] status;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic ptr_zero;
    logic ptr_last;
    logic name_gt;
    logic name_eq;
    logic month_eq;
    logic hold_vld;
    logic match_at_limit;
  } stat_t;

  localparam cmd_t CMD_NOP = '{
    key_ld:    1'b0,
    ptr_op:    PTR_HOLD,
    rd_off:    RD_SAME,
    wr:        WR_NONE,
    cnt:       CNT_HOLD,
    hold_ld:   1'b0,
    hold_clr:  1'b0,
    match_inc: 1'b0,
    match_clr: 1'b0,
    emit:      EMIT_NONE,
    status:    ST_OK,
    last:      1'b0
  };

endpackage

/* rtl/core/srt_ctrl.sv */
module srt_ctrl
  import srt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] op_i,
  input  stat_t      stat_i,
  output logic       busy,
  output cmd_t       cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MON1   = 8'b0000_0010,
    S_MON2   = 8'b0000_0100,
    S_INS    = 8'b0000_1000,
    S_DFIND  = 8'b0001_0000,
    S_DSHIFT = 8'b0010_0000,
    S_SCAN   = 8'b0100_0000,
    S_SEND   = 8'b1000_0000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] op_q, op_d;
  logic       match;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = CMD_NOP;
    match   = (op_q == OP_LIST) || stat_i.month_eq;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d = op_i;
          unique case (op_i)
            OP_INSERT: begin
              if (stat_i.count_full) begin
                cmd_o.emit   = EMIT_ZERO;
                cmd_o.status = ST_FULL;
                cmd_o.last   = 1'b1;
              end else begin
                cmd_o.key_ld = 1'b1;
                cmd_o.ptr_op = PTR_LOAD;
                cmd_o.rd_off = RD_MINUS;
                state_d      = S_MON1;
              end
            end
            OP_DELETE: begin
              if (stat_i.count_zero) begin
                cmd_o.emit   = EMIT_ZERO;
                cmd_o.status = ST_EMPTY;
                cmd_o.last   = 1'b1;
              end else begin
                cmd_o.key_ld = 1'b1;
                cmd_o.ptr_op = PTR_CLEAR;
                state_d      = S_DFIND;
              end
            end
            default: begin
              if (stat_i.count_zero) begin
                cmd_o.emit   = EMIT_ZERO;
                cmd_o.status = (op_i == OP_LIST) ? ST_EMPTY : ST_NO_MATCH;
                cmd_o.last   = 1'b1;
              end else begin
                cmd_o.key_ld    = 1'b1;
                cmd_o.ptr_op    = PTR_CLEAR;
                cmd_o.hold_clr  = 1'b1;
                cmd_o.match_clr = 1'b1;
                state_d         = S_SCAN;
              end
            end
          endcase
        end
      end
      S_MON1: begin
        cmd_o.rd_off = RD_MINUS;
        state_d      = S_MON2;
      end
      S_MON2: begin
        cmd_o.rd_off = RD_MINUS;
        state_d      = S_INS;
      end
      S_INS: begin
        // Records with a greater name move up one place until the gap fits.
        if (!stat_i.ptr_zero && stat_i.name_gt) begin
          cmd_o.wr     = WR_RDATA;
          cmd_o.ptr_op = PTR_DEC;
          cmd_o.rd_off = RD_MINUS;
        end else begin
          cmd_o.wr     = WR_KEY;
          cmd_o.cnt    = CNT_INC;
          cmd_o.emit   = EMIT_KEY;
          cmd_o.status = ST_OK;
          cmd_o.last   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_DFIND: begin
        if (stat_i.name_eq) begin
          cmd_o.hold_ld = 1'b1;
          cmd_o.rd_off  = RD_PLUS;
          state_d       = S_DSHIFT;
        end else if (stat_i.ptr_last) begin
          cmd_o.emit   = EMIT_ZERO;
          cmd_o.status = ST_NOT_FOUND;
          cmd_o.last   = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.ptr_op = PTR_INC;
        end
      end
      S_DSHIFT: begin
        if (!stat_i.ptr_last) begin
          cmd_o.wr     = WR_RDATA;
          cmd_o.ptr_op = PTR_INC;
          cmd_o.rd_off = RD_PLUS;
        end else begin
          cmd_o.cnt    = CNT_DEC;
          cmd_o.emit   = EMIT_HOLD;
          cmd_o.status = ST_OK;
          cmd_o.last   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SCAN: begin
        // A match is parked until the next one shows whether it is the last.
        if (match) begin
          cmd_o.hold_ld   = 1'b1;
          cmd_o.match_inc = 1'b1;
          if (stat_i.hold_vld) begin
            cmd_o.emit   = EMIT_HOLD;
            cmd_o.status = ST_OK;
          end
        end
        if (stat_i.ptr_last || (match && stat_i.match_at_limit)) begin
          state_d = S_SEND;
        end else begin
          cmd_o.ptr_op = PTR_INC;
        end
      end
      S_SEND: begin
        cmd_o.last = 1'b1;
        if (stat_i.hold_vld) begin
          cmd_o.emit   = EMIT_HOLD;
          cmd_o.status = ST_OK;
        end else begin
          cmd_o.emit   = EMIT_ZERO;
          cmd_o.status = ST_NO_MATCH;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_INSERT;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEND) |=> (state_q == S_IDLE))
    else $error("scan end did not return to idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MON1) |-> ($past(state_q) == S_IDLE) && (op_q == OP_INSERT))
    else $error("month preparation entered outside an insert");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit == EMIT_HOLD) |-> stat_i.hold_vld)
    else $error("held record emitted while none is held");

endmodule

/* rtl/core/srt_dpath.sv */
module srt_dpath
  import srt_pkg::*;
#(
  parameter int unsigned MaxRecords = MAX_RECORDS_DEFAULT
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  req_t  req_i,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  output logic  result_valid_o,
  output rsp_t  rsp_o
);

  localparam int unsigned IW = (MaxRecords > 1) ? $clog2(MaxRecords) : 1;
  localparam int unsigned CW = $clog2(MaxRecords + 1);
  localparam int unsigned MW = $clog2(RESULT_LIMIT + 1);

  entry_t          mem [MaxRecords];
  entry_t          rdata_q;
  req_t            key_q;
  entry_t          hold_q;
  logic            hold_vld_q;
  logic [MW-1:0]   nmatch_q;
  logic [IW-1:0]   ptr_q, ptr_d, rd_addr;
  logic [CW-1:0]   count_q, count_d;
  logic [20:0]     q1_q;
  logic [14:0]     q2_q;
  logic [60:0]     prod_wide;
  logic [46:0]     prod_narrow;
  logic [20:0]     month_diff;
  rec_t            key_rec;
  entry_t          wdata;
  rsp_t            rsp_d;
  logic            valid_d;
  logic [CW+4:0]   count_ext;

  assign key_rec = '{
    name_high:  key_q.name_high,
    name_mid:   key_q.name_mid,
    name_low:   key_q.name_low,
    phone_high: key_q.phone_high,
    phone_low:  key_q.phone_low,
    birth_date: key_q.birth_date
  };

  // Birth month is (date / 100) mod 100, computed once at insert and stored.
  assign prod_wide   = 61'(key_q.birth_date) * 61'(DIV100_MUL_WIDE);
  assign prod_narrow = 47'(q1_q) * 47'(DIV100_MUL_NARROW);
  assign month_diff  = q1_q - 21'(q2_q) * MONTH_BASE;

  always_ff @(posedge clk_i) begin
    q1_q <= prod_wide[60:40];
    q2_q <= prod_narrow[46:32];
    if (cmd_i.key_ld) begin
      key_q <= req_i;
    end
    if (cmd_i.hold_ld) begin
      hold_q <= rdata_q;
    end
  end

  always_comb begin
    unique case (cmd_i.ptr_op)
      PTR_HOLD:  ptr_d = ptr_q;
      PTR_LOAD:  ptr_d = IW'(count_q);
      PTR_CLEAR: ptr_d = '0;
      PTR_INC:   ptr_d = ptr_q + IW'(1);
      PTR_DEC:   ptr_d = ptr_q - IW'(1);
      default:   ptr_d = ptr_q;
    endcase
    unique case (cmd_i.rd_off)
      RD_SAME:  rd_addr = ptr_d;
      RD_MINUS: rd_addr = ptr_d - IW'(1);
      RD_PLUS:  rd_addr = ptr_d + IW'(1);
      default:  rd_addr = ptr_d;
    endcase
    unique case (cmd_i.cnt)
      CNT_HOLD: count_d = count_q;
      CNT_INC:  count_d = count_q + CW'(1);
      CNT_DEC:  count_d = count_q - CW'(1);
      default:  count_d = count_q;
    endcase
  end

  assign wdata = (cmd_i.wr == WR_KEY) ?
                 entry_t'{rec: key_rec, month: month_diff[6:0]} : rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr != WR_NONE) begin
      mem[ptr_q] <= wdata;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      count_q    <= '0;
      hold_vld_q <= 1'b0;
      nmatch_q   <= '0;
    end else begin
      ptr_q   <= ptr_d;
      count_q <= count_d;
      if (cmd_i.hold_clr) begin
        hold_vld_q <= 1'b0;
      end else if (cmd_i.hold_ld) begin
        hold_vld_q <= 1'b1;
      end
      if (cmd_i.match_clr) begin
        nmatch_q <= '0;
      end else if (cmd_i.match_inc) begin
        nmatch_q <= nmatch_q + MW'(1);
      end
    end
  end

  assign stat_o.count_zero     = (count_q == '0);
  assign stat_o.count_full     = (count_q >= CW'(MaxRecords));
  assign stat_o.ptr_zero       = (ptr_q == '0);
  assign stat_o.ptr_last       = ((CW'(ptr_q) + CW'(1)) >= count_q);
  assign stat_o.name_gt        =
    {rdata_q.rec.name_high, rdata_q.rec.name_mid, rdata_q.rec.name_low} >
    {key_q.name_high, key_q.name_mid, key_q.name_low};
  assign stat_o.name_eq        =
    {rdata_q.rec.name_high, rdata_q.rec.name_mid, rdata_q.rec.name_low} ==
    {key_q.name_high, key_q.name_mid, key_q.name_low};
  assign stat_o.month_eq       = (rdata_q.month == key_q.search_month);
  assign stat_o.hold_vld       = hold_vld_q;
  assign stat_o.match_at_limit = (nmatch_q == MW'(RESULT_LIMIT - 1));

  assign count_ext = (CW+5)'(count_d);

  always_comb begin
    rec_t src;
    src = '0;
    unique case (cmd_i.emit)
      EMIT_NONE: src = '0;
      EMIT_ZERO: src = '0;
      EMIT_KEY:  src = key_rec;
      EMIT_HOLD: src = hold_q.rec;
      default:   src = '0;
    endcase
    valid_d             = (cmd_i.emit != EMIT_NONE);
    rsp_d.out_name_high  = src.name_high;
    rsp_d.out_name_mid   = src.name_mid;
    rsp_d.out_name_low   = src.name_low;
    rsp_d.out_phone_high = src.phone_high;
    rsp_d.out_phone_low  = src.phone_low;
    rsp_d.out_birth_date = src.birth_date;
    rsp_d.record_count   = count_ext[4:0];
    rsp_d.status         = cmd_i.status;
    rsp_d.last           = cmd_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_d) begin
      rsp_o <= rsp_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxRecords))
    else $error("record count above table depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cnt == CNT_INC) |-> (count_q < CW'(MaxRecords)) && (cmd_i.wr == WR_KEY))
    else $error("insert into a full table");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cnt == CNT_DEC) |-> (count_q != '0))
    else $error("delete from an empty table");

endmodule

/* rtl/core/sorted_record_table.sv */
// Table of up to MaxRecords records kept in name order.
// A command is transferred on the rising edge where start is high and busy
// is low; req_i carries the operation and its fields. Every command gives
// one or more results on rsp_o, each present for exactly one cycle with
// result_valid_o high; the receiver cannot stall, so it must take them as
// they come. The final result of a command has last set.
// Steps of each command:
//   insert:          month preparation, greater names moved up, key written
//   delete:          position found, then the records above it closed up
//   list, find:      a scan over the stored records, up to RESULT_LIMIT matches,
//                    then a closing step
//   full or empty:   the single result appears the cycle after the transfer
// The scans are paced by the single read port of the record memory, which
// visits one stored record per cycle. Insert first passes through S_MON1 and
// S_MON2 for the birth month multiplications, whose result is stored beside
// each record. Busy is high from the transfer until the last result is
// registered; it stays low for full or empty. Reset empties the table at once.
module sorted_record_table
  import srt_pkg::*;
#(
  parameter int unsigned MaxRecords = MAX_RECORDS_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic result_valid_o,
  output rsp_t rsp_o
);

  cmd_t  cmd;
  stat_t stat;

  srt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (req_i.operation),
    .stat_i (stat),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  srt_dpath #(
    .MaxRecords (MaxRecords)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

endmodule

/* dv/testbench.sv */
module testbench;
  import srt_pkg::*;

  localparam int unsigned Depth = 16;
  localparam int unsigned TimeoutCycles = 4000;

  // Predicts the table contents and checks emitted records in order.
  class record_scoreboard;
    rec_t   table_q[$];
    rsp_t   pending_q[$];
    int     errors;

    function void note_request(req_t rq);
      rsp_t  r;
      rec_t  key;
      int    pos;
      int    hits;
      bit    found;
      key = '{rq.name_high, rq.name_mid, rq.name_low, rq.phone_high, rq.phone_low,
              rq.birth_date};
      r = '0;
      r.last = 1'b1;
      case (rq.operation)
        OP_INSERT: begin
          if (table_q.size() >= Depth) begin
            r.status = ST_FULL;
          end else begin
            pos = table_q.size();
            while (pos > 0 && name_of(table_q[pos-1]) > name_of(key)) pos--;
            table_q.insert(pos, key);
            r = emit(key, ST_OK, 1'b1);
          end
          r.record_count = 5'(table_q.size());
          pending_q.push_back(r);
        end
        OP_DELETE: begin
          found = 0;
          if (table_q.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.status = ST_NOT_FOUND;
            foreach (table_q[i]) begin
              if (!found && name_of(table_q[i]) == name_of(key)) begin
                found = 1;
                pos = i;
              end
            end
            if (found) begin
              r = emit(table_q[pos], ST_OK, 1'b1);
              table_q.delete(pos);
            end
          end
          r.record_count = 5'(table_q.size());
          pending_q.push_back(r);
        end
        default: begin
          hits = 0;
          foreach (table_q[i]) begin
            if (hits < RESULT_LIMIT && (rq.operation == OP_LIST ||
                (table_q[i].birth_date % 10000) / 100 == rq.search_month)) begin
              r = emit(table_q[i], ST_OK, 1'b0);
              r.record_count = 5'(table_q.size());
              pending_q.push_back(r);
              hits++;
            end
          end
          if (hits == 0) begin
            r = '0;
            r.last = 1'b1;
            r.status = (rq.operation == OP_LIST) ? ST_EMPTY : ST_NO_MATCH;
            r.record_count = 5'(table_q.size());
            pending_q.push_back(r);
          end else begin
            pending_q[pending_q.size()-1].last = 1'b1;
          end
        end
      endcase
    endfunction

    function logic [159:0] name_of(rec_t e);
      return {e.name_high, e.name_mid, e.name_low};
    endfunction

    function rsp_t emit(rec_t e, logic [2:0] st, logic lst);
      rsp_t r;
      r = '0;
      r.out_name_high = e.name_high;
      r.out_name_mid = e.name_mid;
      r.out_name_low = e.name_low;
      r.out_phone_high = e.phone_high;
      r.out_phone_low = e.phone_low;
      r.out_birth_date = e.birth_date;
      r.status = st;
      r.last = lst;
      return r;
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_q.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.out_name_high !== want.out_name_high) report("out_name_high",
          want.out_name_high, got.out_name_high);
      if (got.out_name_mid !== want.out_name_mid) report("out_name_mid",
          want.out_name_mid, got.out_name_mid);
      if (got.out_name_low !== want.out_name_low) report("out_name_low",
          64'(want.out_name_low), 64'(got.out_name_low));
      if (got.out_phone_high !== want.out_phone_high) report("out_phone_high",
          want.out_phone_high, got.out_phone_high);
      if (got.out_phone_low !== want.out_phone_low) report("out_phone_low",
          64'(want.out_phone_low), 64'(got.out_phone_low));
      if (got.out_birth_date !== want.out_birth_date) report("out_birth_date",
          64'(want.out_birth_date), 64'(got.out_birth_date));
      if (got.record_count !== want.record_count) report("record_count",
          64'(want.record_count), 64'(got.record_count));
      if (got.status !== want.status) report("status", 64'(want.status),
          64'(got.status));
      if (got.last !== want.last) report("last", 64'(want.last), 64'(got.last));
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      $error("%s: expected %0h, got %0h", field, want, got);
      errors++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic result_valid_o;
  rsp_t rsp_o;

  record_scoreboard board = new();
  int idle_pct = 0;
  int stall_cycles = 0;
  logic [63:0] name_pool[8];

  always #1 clk_i = ~clk_i;

  sorted_record_table uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .result_valid_o(result_valid_o), .rsp_o(rsp_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) board.check_result(rsp_o);
    if (result_valid_o || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > TimeoutCycles) begin
      $display("[sorted_record_table] ERROR");
      $finish;
    end
  end

  // One command transfer; the caller's random gap comes first. Start stays
  // high after the transfer so that the next command can follow at once.
  task automatic send(req_t rq);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_request(rq);
  endtask

  function automatic req_t make_req(logic [1:0] op, int pick, int month, int day);
    req_t rq;
    rq = '0;
    rq.operation = op;
    rq.name_high = name_pool[pick % 8];
    rq.name_mid = (pick % 3 == 0) ? {$urandom, $urandom} : 64'(pick / 8);
    rq.name_low = pick % 2;
    rq.phone_high = {$urandom, $urandom};
    rq.phone_low = 56'({$urandom, $urandom});
    rq.birth_date = 27'(1900 * 10000 + month * 100 + day);
    rq.search_month = 7'(month);
    return rq;
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (Depth + 8) @(posedge clk_i);
  endtask

  initial begin
    req_t rq;
    int n;
    name_pool = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h4164616D_00000000,
                  64'h42657468_00000000, 64'h43617273_6F6E0000, 64'h4164616D_00000000,
                  64'h5A6F6500_00000000, 64'h8000_0000_0000_0001};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty-table cases, then fill beyond capacity with extreme fields.
    send(make_req(OP_LIST, 0, 1, 1));
    send(make_req(OP_DELETE, 0, 1, 1));
    send(make_req(OP_FIND, 0, 5, 1));
    for (int i = 0; i < 17; i++) begin
      rq = make_req(OP_INSERT, i, i % 12 + 1, i + 1);
      if (i == 1) begin
        rq.name_high = '1; rq.name_mid = '1; rq.name_low = '1;
        rq.phone_high = '1; rq.phone_low = '1; rq.birth_date = 27'd99999999;
      end
      send(rq);
    end
    send(make_req(OP_LIST, 0, 1, 1));
    send(make_req(OP_FIND, 0, 3, 1));
    send(make_req(OP_FIND, 0, 99, 1));
    rq = make_req(OP_DELETE, 0, 1, 1);
    rq.name_high = 64'h1234;
    send(rq);
    send(make_req(OP_DELETE, 2, 1, 1));
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 31 : (phase == 1) ? 79 : 0;
      for (int i = 0; i < 80; i++) begin
        n = $urandom_range(99);
        rq = make_req(n < 45 ? OP_INSERT : n < 75 ? OP_DELETE : n < 87 ? OP_LIST : OP_FIND,
                      $urandom_range(40), $urandom_range(13), $urandom_range(31));
        if ($urandom_range(9) == 0) begin
          rq.name_high = {$urandom, $urandom};
          rq.name_low = $urandom;
          rq.search_month = 7'($urandom_range(127));
          rq.birth_date = 27'($urandom);
        end
        send(rq);
        if (i == 40) wait_drained();
      end
      wait_drained();
    end

    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("[sorted_record_table] OK");
    end else begin
      $display("[sorted_record_table] ERROR");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/srt_pkg.sv
rtl/core/srt_ctrl.sv
rtl/core/srt_dpath.sv
rtl/core/sorted_record_table.sv
dv/testbench.sv
